### src/one_letter_three_char_decider_top_assert.svh
// Assertion macros shared by the decider RTL; they compile to nothing in synthesis.
`ifndef ONE_LETTER_THREE_CHAR_DECIDER_TOP_ASSERT_SVH
`define ONE_LETTER_THREE_CHAR_DECIDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define OLTCD_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("decider check failed");
`define OLTCD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("decider check failed");
`else
`define OLTCD_ASSERT_SAME(label, pre, post)
`define OLTCD_ASSERT_NEXT(label, pre, post)
`endif

`endif

### src/oltcd_pkg.sv
// Shared types, constants and codes of the one-letter three-character decider.
package oltcd_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int CLASS_COUNT = 36;
  localparam int CLASS_W     = 6;
  localparam int NUM_POS     = 3;
  localparam int POS_W       = 2;
  localparam int SUM_W       = SCORE_BITS + 2;

  localparam logic [CLASS_W-1:0] FIRST_LETTER = CLASS_W'(10);
  localparam logic [CLASS_W:0]   CLASS_LIMIT  = (CLASS_W + 1)'(CLASS_COUNT);
  localparam logic [POS_W-1:0]   POS_LIMIT    = POS_W'(NUM_POS);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECIDE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [CLASS_W-1:0]    cls;
    logic                  seen;
  } best_t;

  typedef struct packed {
    best_t letter;
    best_t digit;
  } pos_best_t;

  // Score update request from the input stage to the trackers.
  typedef struct packed {
    logic                  en;
    logic                  clr;
    logic [POS_W-1:0]      pos;
    logic [CLASS_W-1:0]    cls;
    logic [SCORE_BITS-1:0] score;
  } upd_t;

  typedef struct packed {
    logic [CLASS_W-1:0] code_first;
    logic [CLASS_W-1:0] code_second;
    logic [CLASS_W-1:0] code_third;
    logic               kept_prior;
  } res_t;

  localparam pos_best_t POS_RESET = '{
    letter: '{score: '0, cls: FIRST_LETTER, seen: 1'b0},
    digit:  '{score: '0, cls: '0,           seen: 1'b0}
  };

endpackage

### src/oltcd_tracker.sv
// Running best digit and best letter per character position.
module oltcd_tracker (
  input  logic                                           clk,
  input  logic                                           rst,
  input  oltcd_pkg::upd_t                                upd,
  output oltcd_pkg::pos_best_t [oltcd_pkg::NUM_POS-1:0]  best
);

  oltcd_pkg::pos_best_t [oltcd_pkg::NUM_POS-1:0] best_next;

  // A new score wins if the group is empty, it is higher, or it ties with a lower class.
  function automatic logic wins(input oltcd_pkg::best_t b,
                                input logic [oltcd_pkg::SCORE_BITS-1:0] s,
                                input logic [oltcd_pkg::CLASS_W-1:0] c);
    return !b.seen || (s > b.score) || ((s == b.score) && (c < b.cls));
  endfunction

  always_comb begin
    best_next = best;
    if (upd.clr) begin
      for (int p = 0; p < oltcd_pkg::NUM_POS; p++) begin
        best_next[p] = oltcd_pkg::POS_RESET;
      end
    end else if (upd.en) begin
      if (upd.cls >= oltcd_pkg::FIRST_LETTER) begin
        if (wins(best[upd.pos].letter, upd.score, upd.cls)) begin
          best_next[upd.pos].letter = '{score: upd.score, cls: upd.cls, seen: 1'b1};
        end
      end else begin
        if (wins(best[upd.pos].digit, upd.score, upd.cls)) begin
          best_next[upd.pos].digit = '{score: upd.score, cls: upd.cls, seen: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < oltcd_pkg::NUM_POS; p++) begin
        best[p] <= oltcd_pkg::POS_RESET;
      end
    end else begin
      best <= best_next;
    end
  end

endmodule

### src/oltcd_decide.sv
// Chooses the letter position from the tracked bests, or keeps the prior codes.
module oltcd_decide (
  input  oltcd_pkg::pos_best_t [oltcd_pkg::NUM_POS-1:0] best,
  input  logic [oltcd_pkg::CLASS_W-1:0]                 prior_first,
  input  logic [oltcd_pkg::CLASS_W-1:0]                 prior_second,
  input  logic [oltcd_pkg::CLASS_W-1:0]                 prior_third,
  output oltcd_pkg::res_t                               res
);

  logic                        let_a;
  logic                        let_b;
  logic                        let_c;
  logic [1:0]                  letter_cnt;
  logic [oltcd_pkg::SUM_W-1:0] sum_l0;
  logic [oltcd_pkg::SUM_W-1:0] sum_l1;
  logic [oltcd_pkg::SUM_W-1:0] sum_l2;

  assign let_a      = prior_first  >= oltcd_pkg::FIRST_LETTER;
  assign let_b      = prior_second >= oltcd_pkg::FIRST_LETTER;
  assign let_c      = prior_third  >= oltcd_pkg::FIRST_LETTER;
  assign letter_cnt = {1'b0, let_a} + {1'b0, let_b} + {1'b0, let_c};

  assign sum_l0 = oltcd_pkg::SUM_W'(best[0].letter.score) + oltcd_pkg::SUM_W'(best[1].digit.score)
                + oltcd_pkg::SUM_W'(best[2].digit.score);
  assign sum_l1 = oltcd_pkg::SUM_W'(best[0].digit.score) + oltcd_pkg::SUM_W'(best[1].letter.score)
                + oltcd_pkg::SUM_W'(best[2].digit.score);
  assign sum_l2 = oltcd_pkg::SUM_W'(best[0].digit.score) + oltcd_pkg::SUM_W'(best[1].digit.score)
                + oltcd_pkg::SUM_W'(best[2].letter.score);

  // Letter-first is the fallback whenever no other arrangement is strictly largest.
  always_comb begin
    if (letter_cnt == 2'd1) begin
      res = '{code_first: prior_first, code_second: prior_second,
              code_third: prior_third, kept_prior: 1'b1};
    end else if ((sum_l2 > sum_l1) && (sum_l2 > sum_l0)) begin
      res = '{code_first: best[0].digit.cls, code_second: best[1].digit.cls,
              code_third: best[2].letter.cls, kept_prior: 1'b0};
    end else if ((sum_l1 > sum_l0) && (sum_l1 > sum_l2)) begin
      res = '{code_first: best[0].digit.cls, code_second: best[1].letter.cls,
              code_third: best[2].digit.cls, kept_prior: 1'b0};
    end else begin
      res = '{code_first: best[0].letter.cls, code_second: best[1].digit.cls,
              code_third: best[2].digit.cls, kept_prior: 1'b0};
    end
  end

endmodule

### src/one_letter_three_char_decider_top.sv
// Top level of the one-letter three-character decider.
// A decide item's result is loaded into the result register when the item leaves the input register.
// Throughput: one item per cycle; a decide item waits only while the result register is stalled.
// Score items never wait on the output side, since they produce no result.
// Reset (synchronous, active high) empties both registers and clears every tracker.
`include "one_letter_three_char_decider_top_assert.svh"

module one_letter_three_char_decider_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [oltcd_pkg::POS_W-1:0]      position,
  input  logic [oltcd_pkg::CLASS_W-1:0]    class_code,
  input  logic [oltcd_pkg::SCORE_BITS-1:0] score,
  input  logic [oltcd_pkg::CLASS_W-1:0]    prior_first,
  input  logic [oltcd_pkg::CLASS_W-1:0]    prior_second,
  input  logic [oltcd_pkg::CLASS_W-1:0]    prior_third,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [oltcd_pkg::CLASS_W-1:0]    code_first,
  output logic [oltcd_pkg::CLASS_W-1:0]    code_second,
  output logic [oltcd_pkg::CLASS_W-1:0]    code_third,
  output logic                             kept_prior
);

  logic                                          s1_valid;
  oltcd_pkg::cmd_t                               s1_cmd;
  logic [oltcd_pkg::POS_W-1:0]                   s1_position;
  logic [oltcd_pkg::CLASS_W-1:0]                 s1_class;
  logic [oltcd_pkg::SCORE_BITS-1:0]              s1_score;
  logic [oltcd_pkg::CLASS_W-1:0]                 s1_prior_first;
  logic [oltcd_pkg::CLASS_W-1:0]                 s1_prior_second;
  logic [oltcd_pkg::CLASS_W-1:0]                 s1_prior_third;
  logic                                          s1_adv;
  logic                                          out_load;
  oltcd_pkg::upd_t                               upd;
  oltcd_pkg::pos_best_t [oltcd_pkg::NUM_POS-1:0] best;
  oltcd_pkg::res_t                               res;

  // A score item always moves on; a decide item needs the result register free.
  assign s1_adv   = s1_valid && ((s1_cmd == oltcd_pkg::CMD_LOAD) || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign out_load = s1_adv && (s1_cmd == oltcd_pkg::CMD_DECIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd          <= oltcd_pkg::cmd_t'(cmd);
      s1_position     <= position;
      s1_class        <= class_code;
      s1_score        <= score;
      s1_prior_first  <= prior_first;
      s1_prior_second <= prior_second;
      s1_prior_third  <= prior_third;
    end
  end

  // Out-of-range positions and classes are dropped here.
  always_comb begin
    upd.en    = s1_adv && (s1_cmd == oltcd_pkg::CMD_LOAD)
             && (s1_position < oltcd_pkg::POS_LIMIT)
             && ({1'b0, s1_class} < oltcd_pkg::CLASS_LIMIT);
    upd.clr   = out_load;
    upd.pos   = s1_position;
    upd.cls   = s1_class;
    upd.score = s1_score;
  end

  oltcd_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .best (best)
  );

  oltcd_decide u_decide (
    .best         (best),
    .prior_first  (s1_prior_first),
    .prior_second (s1_prior_second),
    .prior_third  (s1_prior_third),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code_first  <= res.code_first;
      code_second <= res.code_second;
      code_third  <= res.code_third;
      kept_prior  <= res.kept_prior;
    end
  end

  // Every delivered result holds exactly one letter code.
  `OLTCD_ASSERT_SAME(a_one_letter, out_valid, $countones({code_first >= oltcd_pkg::FIRST_LETTER, code_second >= oltcd_pkg::FIRST_LETTER, code_third >= oltcd_pkg::FIRST_LETTER}) == 1)
  // A decide transfer leaves all trackers empty.
  `OLTCD_ASSERT_NEXT(a_cleared, out_load, !best[0].letter.seen && !best[0].digit.seen && !best[1].letter.seen && !best[1].digit.seen && !best[2].letter.seen && !best[2].digit.seen)
  // Input waits only behind a decide item blocked by a stalled result.
  `OLTCD_ASSERT_SAME(a_stall_cause, in_stall, s1_valid && (s1_cmd == oltcd_pkg::CMD_DECIDE) && out_valid && out_stall)

endmodule

### verif/one_letter_three_char_decider_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the one-letter three-character decider.
module one_letter_three_char_decider_top_test;
  import oltcd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int ITEM_TARGET = 550;

  // Tracks the per-position best digit and letter and queues the codes each decision owes.
  class decider_scoreboard;
    pos_best_t trk[NUM_POS];
    res_t      pending_codes[$];
    int        errors;

    function new();
      foreach (trk[p]) trk[p] = POS_RESET;
      errors = 0;
    endfunction

    function best_t better_of(best_t b, logic [CLASS_W-1:0] cls, logic [SCORE_BITS-1:0] sc);
      if (!b.seen || sc > b.score || (sc == b.score && cls < b.cls)) begin
        b.score = sc;
        b.cls   = cls;
        b.seen  = 1'b1;
      end
      return b;
    endfunction

    function res_t decide_codes(logic [CLASS_W-1:0] pa, logic [CLASS_W-1:0] pb,
                                logic [CLASS_W-1:0] pc);
      int               letters;
      logic [SUM_W-1:0] s_cnn;
      logic [SUM_W-1:0] s_ncn;
      logic [SUM_W-1:0] s_nnc;
      res_t             r;
      letters = int'(pa >= FIRST_LETTER) + int'(pb >= FIRST_LETTER) + int'(pc >= FIRST_LETTER);
      if (letters == 1) begin
        r.code_first  = pa;
        r.code_second = pb;
        r.code_third  = pc;
        r.kept_prior  = 1'b1;
      end else begin
        s_cnn = SUM_W'(trk[0].letter.score) + SUM_W'(trk[1].digit.score)
              + SUM_W'(trk[2].digit.score);
        s_ncn = SUM_W'(trk[0].digit.score) + SUM_W'(trk[1].letter.score)
              + SUM_W'(trk[2].digit.score);
        s_nnc = SUM_W'(trk[0].digit.score) + SUM_W'(trk[1].digit.score)
              + SUM_W'(trk[2].letter.score);
        r.kept_prior = 1'b0;
        // The letter-first arrangement wins every tie.
        if (s_nnc > s_ncn && s_nnc > s_cnn) begin
          r.code_first  = trk[0].digit.cls;
          r.code_second = trk[1].digit.cls;
          r.code_third  = trk[2].letter.cls;
        end else if (s_ncn > s_cnn && s_ncn > s_nnc) begin
          r.code_first  = trk[0].digit.cls;
          r.code_second = trk[1].letter.cls;
          r.code_third  = trk[2].digit.cls;
        end else begin
          r.code_first  = trk[0].letter.cls;
          r.code_second = trk[1].digit.cls;
          r.code_third  = trk[2].digit.cls;
        end
      end
      return r;
    endfunction

    function void take_item(cmd_t op, logic [POS_W-1:0] pos, logic [CLASS_W-1:0] cls,
                            logic [SCORE_BITS-1:0] sc, logic [CLASS_W-1:0] pa,
                            logic [CLASS_W-1:0] pb, logic [CLASS_W-1:0] pc);
      if (op == CMD_LOAD) begin
        if (pos < POS_LIMIT && {1'b0, cls} < CLASS_LIMIT) begin
          if (cls >= FIRST_LETTER) trk[pos].letter = better_of(trk[pos].letter, cls, sc);
          else trk[pos].digit = better_of(trk[pos].digit, cls, sc);
        end
      end else begin
        pending_codes.push_back(decide_codes(pa, pb, pc));
        foreach (trk[p]) trk[p] = POS_RESET;
      end
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_codes(res_t got);
      res_t want;
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d %0d %0d kept %0d",
                 $time, got.code_first, got.code_second, got.code_third, got.kept_prior);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      compare_field("code_first", want.code_first, got.code_first);
      compare_field("code_second", want.code_second, got.code_second);
      compare_field("code_third", want.code_third, got.code_third);
      compare_field("kept_prior", want.kept_prior, got.kept_prior);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cmd;
  logic [POS_W-1:0]      position;
  logic [CLASS_W-1:0]    class_code;
  logic [SCORE_BITS-1:0] score;
  logic [CLASS_W-1:0]    prior_first;
  logic [CLASS_W-1:0]    prior_second;
  logic [CLASS_W-1:0]    prior_third;
  logic                  out_valid;
  logic                  out_stall;
  logic [CLASS_W-1:0]    code_first;
  logic [CLASS_W-1:0]    code_second;
  logic [CLASS_W-1:0]    code_third;
  logic                  kept_prior;

  decider_scoreboard book;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  int  gap_pct      = 35;
  int  stall_pct    = 35;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;

  one_letter_three_char_decider_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .position     (position),
    .class_code   (class_code),
    .score        (score),
    .prior_first  (prior_first),
    .prior_second (prior_second),
    .prior_third  (prior_third),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_first   (code_first),
    .code_second  (code_second),
    .code_third   (code_third),
    .kept_prior   (kept_prior)
  );

  always #5 clk = ~clk;

  // Results are checked before the same edge's input transfer is taken in.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        book.check_codes('{code_first: code_first, code_second: code_second,
                           code_third: code_third, kept_prior: kept_prior});
      end
      if (in_valid && !in_stall) begin
        book.take_item(cmd_t'(cmd), position, class_code, score,
                       prior_first, prior_second, prior_third);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("one_letter_three_char_decider_top regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the result side backs up.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(cmd_t op, logic [POS_W-1:0] pos, logic [CLASS_W-1:0] cls,
                           logic [SCORE_BITS-1:0] sc, logic [CLASS_W-1:0] pa,
                           logic [CLASS_W-1:0] pb, logic [CLASS_W-1:0] pc);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    in_valid     = 1'b1;
    cmd          = op;
    position     = pos;
    class_code   = cls;
    score        = sc;
    prior_first  = pa;
    prior_second = pb;
    prior_third  = pc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  // Prior fields of a score transfer are don't-care, so they get random values.
  task automatic load_score(logic [POS_W-1:0] pos, logic [CLASS_W-1:0] cls,
                            logic [SCORE_BITS-1:0] sc);
    send_item(CMD_LOAD, pos, cls, sc, CLASS_W'($urandom), CLASS_W'($urandom),
              CLASS_W'($urandom));
  endtask

  task automatic request_decision(logic [CLASS_W-1:0] pa, logic [CLASS_W-1:0] pb,
                                  logic [CLASS_W-1:0] pc);
    send_item(CMD_DECIDE, POS_W'($urandom), CLASS_W'($urandom), SCORE_BITS'($urandom),
              pa, pb, pc);
  endtask

  // One plate: a run of scores followed by a decision, with some malformed score items mixed in.
  task automatic send_plate();
    int                    n;
    int                    letter_at;
    logic [CLASS_W-1:0]    cls;
    logic [SCORE_BITS-1:0] sc;
    logic [CLASS_W-1:0]    pr[NUM_POS];
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(3))
        0: sc = SCORE_BITS'($urandom_range(0, 3));
        1: sc = SCORE_BITS'($urandom);
        2: sc = SCORE_BITS'(65535 - $urandom_range(0, 2));
        default: sc = SCORE_BITS'($urandom_range(0, 300));
      endcase
      if ($urandom_range(99) < 8) begin
        load_score(POS_W'($urandom), CLASS_W'($urandom), sc);
      end else begin
        cls = $urandom_range(1) ? CLASS_W'($urandom_range(0, 9))
                                : CLASS_W'($urandom_range(10, CLASS_COUNT - 1));
        load_score(POS_W'($urandom_range(0, NUM_POS - 1)), cls, sc);
      end
    end
    case ($urandom_range(2))
      0: begin
        letter_at = $urandom_range(0, NUM_POS - 1);
        foreach (pr[p]) pr[p] = (p == letter_at) ? CLASS_W'($urandom_range(10, 63))
                                                 : CLASS_W'($urandom_range(0, 9));
      end
      1: foreach (pr[p]) pr[p] = CLASS_W'($urandom);
      default: foreach (pr[p]) pr[p] = CLASS_W'($urandom_range(0, 9));
    endcase
    request_decision(pr[0], pr[1], pr[2]);
  endtask

  initial begin
    book         = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_LOAD;
    position     = '0;
    class_code   = '0;
    score        = '0;
    prior_first  = '0;
    prior_second = '0;
    prior_third  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty trackers report the default letter and digit classes.
    request_decision(0, 0, 0);
    // A zero score is still taken as the first of its group; equal scores go to the lower class.
    load_score(0, 35, 0);
    load_score(0, 20, 0);
    load_score(0, 25, 0);
    load_score(1, 9, 16'hFFFF);
    load_score(1, 3, 16'hFFFF);
    load_score(2, 0, 100);
    // Position 3 and classes past the last letter are dropped.
    load_score(POS_LIMIT, 5, 16'hFFFF);
    load_score(2, CLASS_W'(CLASS_COUNT), 16'hFFFF);
    load_score(2, 63, 16'hFFFF);
    request_decision(0, 0, 0);
    // Exactly one letter among the priors: the priors come back, out-of-range codes as letters.
    request_decision(5, 35, 9);
    request_decision(63, 1, 2);
    // Letter in third place strictly ahead, with sums at full width.
    load_score(2, 35, 16'hFFFF);
    load_score(0, 9, 16'hFFFF);
    load_score(1, 0, 16'hFFFF);
    request_decision(FIRST_LETTER, 35, 63);
    // Letter in second place strictly ahead.
    load_score(1, FIRST_LETTER, 500);
    request_decision(1, 2, 3);
    // Letter-first and letter-second tie: letter-first wins.
    load_score(0, 11, 7);
    load_score(1, 12, 7);
    request_decision(40, 50, 60);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 150) hold_req = 1'b1;
      if (items_sent >= 320 && items_sent < 440) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 35;
        stall_pct = 35;
      end
      send_plate();
    end

    while (book.pending_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) $display("one_letter_three_char_decider_top regression: pass");
    else $display("one_letter_three_char_decider_top regression: fail");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/oltcd_pkg.sv
src/oltcd_tracker.sv
src/oltcd_decide.sv
src/one_letter_three_char_decider_top.sv
verif/one_letter_three_char_decider_top_test.sv
